// File: rtl/core/dsdc_pkg.sv
// Shared types, microprogram and calendar tables for the day serial / date converter.
// Used by dsdc_sequencer, dsdc_datapath and the top level; depends on nothing.
package dsdc_pkg;

    localparam int PC_W   = 5;
    localparam int IDX_W  = 4;
    localparam int SER_W  = 22;
    localparam int YEAR_W = 14;
    localparam int ACC_W  = 23;

    // Datapath operations.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_REDUCE = 3'd1;
    localparam logic [2:0] OP_LEAP   = 3'd2;
    localparam logic [2:0] OP_MWALK  = 3'd3;
    localparam logic [2:0] OP_DDONE  = 3'd4;
    localparam logic [2:0] OP_MSUM   = 3'd5;
    localparam logic [2:0] OP_EDONE  = 3'd6;
    localparam logic [2:0] OP_DONE   = 3'd7;

    // Which digit register takes the quotient bit of a reduce step.
    localparam logic [1:0] Q_NONE = 2'd0;
    localparam logic [1:0] Q_B    = 2'd1;
    localparam logic [1:0] Q_C    = 2'd2;
    localparam logic [1:0] Q_D    = 2'd3;

    // Sequencing kinds.
    localparam logic [2:0] BR_NEXT = 3'd0;
    localparam logic [2:0] BR_LOOP = 3'd1;
    localparam logic [2:0] BR_ENC  = 3'd2;
    localparam logic [2:0] BR_JUMP = 3'd3;
    localparam logic [2:0] BR_END  = 3'd4;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_LEAP  = 5'd15;
    localparam logic [PC_W-1:0] PC_MWALK = 5'd16;
    localparam logic [PC_W-1:0] PC_DDONE = 5'd17;
    localparam logic [PC_W-1:0] PC_MSUM  = 5'd18;
    localparam logic [PC_W-1:0] PC_EDONE = 5'd19;
    localparam logic [PC_W-1:0] PC_DONE  = 5'd20;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic [1:0]       qsel;
        logic [2:0]       br;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic loop;
        logic enc;
    } stat_t;

    typedef struct packed {
        logic [SER_W-1:0]  serial;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [2:0]        weekday;
        logic              leap;
        logic              error;
    } result_t;

    // One row of the period table: days, years and days modulo 7.
    typedef struct packed {
        logic [ACC_W-1:0]  days;
        logic [YEAR_W-1:0] years;
        logic [2:0]        wk;
    } period_t;

    // Periods of 400, 100, 4 and 1 years, each scaled by the powers of two
    // that its digit needs, largest first.
    function automatic period_t period(input logic [IDX_W-1:0] idx);
        period_t p;
        case (idx)
            4'd0:    p = '{days: 23'd4675104, years: 14'd12800, wk: 3'd0};
            4'd1:    p = '{days: 23'd2337552, years: 14'd6400,  wk: 3'd0};
            4'd2:    p = '{days: 23'd1168776, years: 14'd3200,  wk: 3'd0};
            4'd3:    p = '{days: 23'd584388,  years: 14'd1600,  wk: 3'd0};
            4'd4:    p = '{days: 23'd292194,  years: 14'd800,   wk: 3'd0};
            4'd5:    p = '{days: 23'd146097,  years: 14'd400,   wk: 3'd0};
            4'd6:    p = '{days: 23'd73048,   years: 14'd200,   wk: 3'd3};
            4'd7:    p = '{days: 23'd36524,   years: 14'd100,   wk: 3'd5};
            4'd8:    p = '{days: 23'd23376,   years: 14'd64,    wk: 3'd3};
            4'd9:    p = '{days: 23'd11688,   years: 14'd32,    wk: 3'd5};
            4'd10:   p = '{days: 23'd5844,    years: 14'd16,    wk: 3'd6};
            4'd11:   p = '{days: 23'd2922,    years: 14'd8,     wk: 3'd3};
            4'd12:   p = '{days: 23'd1461,    years: 14'd4,     wk: 3'd5};
            4'd13:   p = '{days: 23'd730,     years: 14'd2,     wk: 3'd2};
            4'd14:   p = '{days: 23'd365,     years: 14'd1,     wk: 3'd1};
            default: p = '{days: 23'd365,     years: 14'd1,     wk: 3'd1};
        endcase
        return p;
    endfunction

    // Length of a month; 29 February only in leap years.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] n;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd2:                    n = lp ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    // A month length lies in 28..31, so its residue modulo 7 is the excess over 28.
    function automatic logic [2:0] month_wk(input logic [4:0] n);
        logic [4:0] d;
        d = n - 5'd28;
        return d[2:0];
    endfunction

    // Residue modulo 7 of a 5-bit value by a short compare chain.
    function automatic logic [2:0] mod7_5(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd28)
            r = v - 5'd28;
        else if (v >= 5'd21)
            r = v - 5'd21;
        else if (v >= 5'd14)
            r = v - 5'd14;
        else if (v >= 5'd7)
            r = v - 5'd7;
        else
            r = v;
        return r[2:0];
    endfunction

    // Sum of two residues modulo 7.
    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 4'd7)
            s = s - 4'd7;
        return s[2:0];
    endfunction

    // Microprogram ROM.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, idx: '0, qsel: Q_NONE, br: BR_NEXT, target: '0};
        case (pc) inside
            [5'd0:5'd5]:
            begin
                w.op  = OP_REDUCE;
                w.idx = pc[IDX_W-1:0];
            end
            [5'd6:5'd7]:
            begin
                w.op   = OP_REDUCE;
                w.idx  = pc[IDX_W-1:0];
                w.qsel = Q_B;
            end
            [5'd8:5'd12]:
            begin
                w.op   = OP_REDUCE;
                w.idx  = pc[IDX_W-1:0];
                w.qsel = Q_C;
            end
            [5'd13:5'd14]:
            begin
                w.op   = OP_REDUCE;
                w.idx  = pc[IDX_W-1:0];
                w.qsel = Q_D;
            end
            PC_LEAP:
            begin
                w.op     = OP_LEAP;
                w.br     = BR_ENC;
                w.target = PC_MSUM;
            end
            PC_MWALK:
            begin
                w.op = OP_MWALK;
                w.br = BR_LOOP;
            end
            PC_DDONE:
            begin
                w.op     = OP_DDONE;
                w.br     = BR_JUMP;
                w.target = PC_DONE;
            end
            PC_MSUM:
            begin
                w.op = OP_MSUM;
                w.br = BR_LOOP;
            end
            PC_EDONE:
            begin
                w.op = OP_EDONE;
            end
            default:
            begin
                w.op = OP_DONE;
                w.br = BR_END;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/dsdc_sequencer.sv
// Step counter and microprogram ROM of the day serial / date converter.
// Depends on dsdc_pkg for the control word, status and program constants.
module dsdc_sequencer
    import dsdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy,
    output logic  done
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    ctrl_t           word;

    // Fetch the control word; an idle sequencer issues no operation.
    always_comb
    begin
        word = ucode(pc_reg);
        ctrl = word;
        if (!busy_reg)
            ctrl = '{op: OP_NOP, idx: '0, qsel: Q_NONE, br: BR_END, target: '0};
    end

    assign done = busy_reg && (word.br == BR_END) && out_free;
    assign busy = busy_reg;

    // Next step: fall through, stay in a loop, branch on encode or jump.
    always_comb
    begin
        pc_next   = pc_reg + 5'd1;
        busy_next = busy_reg;
        case (word.br)
            BR_NEXT: pc_next = pc_reg + 5'd1;
            BR_LOOP: pc_next = stat.loop ? pc_reg : pc_reg + 5'd1;
            BR_ENC:  pc_next = stat.enc ? word.target : pc_reg + 5'd1;
            BR_JUMP: pc_next = word.target;
            BR_END:
            begin
                pc_next = pc_reg;
                if (out_free)
                    busy_next = 1'b0;
            end
            default: pc_next = pc_reg + 5'd1;
        endcase
        if (!busy_reg)
        begin
            pc_next   = '0;
            busy_next = start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: rtl/core/dsdc_datapath.sv
// Datapath of the day serial / date converter: period reduction, leap rule,
// month walk and weekday residue, driven one control word per cycle.
// Depends on dsdc_pkg for the control word, tables and helper functions.
module dsdc_datapath
    import dsdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  logic              clk,
    input  logic              start,
    input  logic              kind,
    input  logic [SER_W-1:0]  serial_in,
    input  logic [4:0]        day_in,
    input  logic [3:0]        month_in,
    input  logic [YEAR_W-1:0] year_in,
    input  ctrl_t             ctrl,
    output stat_t             stat,
    output result_t           res
);

    // Last serial that still falls within MAX_YEAR.
    localparam longint      LastP       = longint'(MAX_YEAR);
    localparam logic [31:0] SERIAL_LAST =
        32'(365 * LastP + LastP / 4 - LastP / 100 + LastP / 400 - 1);

    logic [ACC_W-1:0]  a_reg;
    logic [ACC_W-1:0]  b_reg;
    logic [2:0]        wk_reg;
    logic [1:0]        qb_reg;
    logic [4:0]        qc_reg;
    logic [1:0]        qd_reg;
    logic [3:0]        month_reg;
    logic [3:0]        mon_in_reg;
    logic [4:0]        day_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [SER_W-1:0]  serial_reg;
    logic              enc_reg;
    logic              err_reg;
    logic              leap_reg;

    period_t           per;
    logic [ACC_W-1:0]  sub_val;
    logic [ACC_W-1:0]  add_val;
    logic              take;
    logic [4:0]        mlen;
    logic              walk_ok;
    logic              msum_ok;
    logic              leap_calc;
    logic              bad_in;
    logic [4:0]        day_m1;

    // Decode subtracts day periods and counts years; encode does the reverse.
    always_comb
    begin
        per     = period(ctrl.idx);
        sub_val = enc_reg ? ACC_W'(per.years) : per.days;
        add_val = enc_reg ? per.days : ACC_W'(per.years);
        take    = a_reg >= sub_val;
    end

    // Month loop conditions.
    assign mlen    = month_len(month_reg, leap_reg);
    assign walk_ok = (month_reg < 4'd12) && (a_reg >= ACC_W'(mlen));
    assign msum_ok = month_reg < mon_in_reg;
    assign day_m1  = day_reg - 5'd1;

    // Leap from the digits of year - 1: last year of a 4-year group, and not
    // a century end unless the 400-year period also ends there.
    assign leap_calc = (qd_reg == 2'd3) && ((qc_reg != 5'd24) || (qb_reg == 2'd3));

    // Range checks done when the word is taken.
    always_comb
    begin
        if (kind)
            bad_in = (year_in == '0) || ({18'd0, year_in} > 32'(MAX_YEAR))
                || (month_in == 4'd0) || (month_in > 4'd12) || (day_in == 5'd0);
        else
            bad_in = {10'd0, serial_in} > SERIAL_LAST;
    end

    assign stat.loop = (ctrl.op == OP_MWALK) ? walk_ok : msum_ok;
    assign stat.enc  = enc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg      <= kind ? ACC_W'(year_in) - 23'd1 : ACC_W'(serial_in);
            b_reg      <= '0;
            wk_reg     <= '0;
            qb_reg     <= '0;
            qc_reg     <= '0;
            qd_reg     <= '0;
            month_reg  <= 4'd1;
            mon_in_reg <= month_in;
            day_reg    <= day_in;
            year_reg   <= year_in;
            serial_reg <= serial_in;
            enc_reg    <= kind;
            err_reg    <= bad_in;
            leap_reg   <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                OP_REDUCE:
                begin
                    if (take)
                    begin
                        a_reg  <= a_reg - sub_val;
                        b_reg  <= b_reg + add_val;
                        wk_reg <= add_mod7(wk_reg, per.wk);
                    end
                    case (ctrl.qsel)
                        Q_B:     qb_reg <= {qb_reg[0], take};
                        Q_C:     qc_reg <= {qc_reg[3:0], take};
                        Q_D:     qd_reg <= {qd_reg[0], take};
                        default: ;
                    endcase
                end
                OP_LEAP:
                begin
                    leap_reg <= leap_calc;
                    if (enc_reg)
                    begin
                        if (day_reg > month_len(mon_in_reg, leap_calc))
                            err_reg <= 1'b1;
                    end
                    else
                        year_reg <= YEAR_W'(b_reg + 23'd1);
                end
                OP_MWALK:
                begin
                    if (walk_ok)
                    begin
                        a_reg     <= a_reg - ACC_W'(mlen);
                        month_reg <= month_reg + 4'd1;
                        wk_reg    <= add_mod7(wk_reg, month_wk(mlen));
                    end
                end
                OP_DDONE:
                begin
                    day_reg <= a_reg[4:0] + 5'd1;
                    wk_reg  <= add_mod7(wk_reg, mod7_5(a_reg[4:0]));
                end
                OP_MSUM:
                begin
                    if (msum_ok)
                    begin
                        b_reg     <= b_reg + ACC_W'(mlen);
                        month_reg <= month_reg + 4'd1;
                        wk_reg    <= add_mod7(wk_reg, month_wk(mlen));
                    end
                end
                OP_EDONE:
                begin
                    serial_reg <= SER_W'(b_reg + ACC_W'(day_m1));
                    wk_reg     <= add_mod7(wk_reg, mod7_5(day_m1));
                end
                default: ;
            endcase
        end
    end

    // Result fields, all zero but the flag on an error.
    always_comb
    begin
        res = '0;
        if (err_reg)
            res.error = 1'b1;
        else
        begin
            res.serial  = serial_reg;
            res.year    = year_reg;
            res.month   = month_reg;
            res.day     = day_reg;
            res.weekday = wk_reg;
            res.leap    = leap_reg;
        end
    end

endmodule

// File: rtl/core/day_serial_date_converter_core.sv
// Top level of the day serial / date converter: stream ports and output register.
// Depends on dsdc_pkg, dsdc_sequencer and dsdc_datapath.
//
// Usage: one request word enters on the s_ channel; s_tuser selects decode (0,
// serial to date) or encode (1, date to serial). Exactly one result word leaves on
// the m_ channel, carrying the date fields, serial, weekday (0 is Monday), leap
// flag and error flag; on an error every other field is zero.
// A request runs through a microprogram of 21 steps: fifteen period-reduction
// steps (400, 100, 4 and 1 year digits), a leap step, a month loop that steps
// once for each month passed, a day step and a final step. The month loop makes
// the run time vary with the month. One request is in flight at a time: s_tready
// is low while the sequencer runs and rises as the result is loaded into the
// output register, so a new request is taken only after the previous result is loaded.
// A finished result waits in the output register while a new request is taken;
// if the receiver still stalls when the next result is done, the sequencer
// holds at its last step and s_tready stays low until the word is taken.
// Reset clears the sequencer and the output valid flag; no other setup is needed.
module day_serial_date_converter_core
    import dsdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // serial_in[21:0], day_in[26:22], month_in[30:27],
                                   // year_in[44:31], zero fill [47:45]
    input  logic        s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // serial_out[21:0], year_out[35:22], month_out[39:36],
                                   // day_out[44:40], weekday[47:45], leap[48],
                                   // error[49], zero fill [55:50]
);

    logic        start;
    logic        busy;
    logic        done;
    logic        out_free;
    ctrl_t       ctrl;
    stat_t       stat;
    result_t     res;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [55:0] m_tdata_reg;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    dsdc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    dsdc_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk       (clk),
        .start     (start),
        .kind      (s_tuser),
        .serial_in (s_tdata[21:0]),
        .day_in    (s_tdata[26:22]),
        .month_in  (s_tdata[30:27]),
        .year_in   (s_tdata[44:31]),
        .ctrl      (ctrl),
        .stat      (stat),
        .res       (res)
    );

    // Output register valid flag.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (done)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // Output register payload, loaded when the program ends.
    always_ff @(posedge clk)
    begin
        if (done)
            m_tdata_reg <= {6'd0, res.error, res.leap, res.weekday, res.day,
                            res.month, res.year, res.serial};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/dsdc_checker.sv
// Port-level checks for the day serial / date converter, bound to the top level.
// Depends only on the ports of day_serial_date_converter_core.
module dsdc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A taken request keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still running");

    // No result can appear in the cycle after a request is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // An error word carries nothing but the flag.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[49]) |-> (m_tdata[48:0] == 49'd0))
        else $error("error word with nonzero fields");

    // A good word holds a real month, day and weekday.
    a_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[49]) |-> ((m_tdata[39:36] != 4'd0)
            && (m_tdata[39:36] <= 4'd12) && (m_tdata[44:40] != 5'd0)
            && (m_tdata[47:45] != 3'd7)))
        else $error("result fields out of range");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind day_serial_date_converter_core dsdc_checker u_dsdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the day serial / date converter, with a scoreboard class.
// Depends on dsdc_pkg and day_serial_date_converter_core; drives both stream ports directly.
module tb_top;
    import dsdc_pkg::*;

    localparam int          MAX_YEAR     = 9999;
    localparam bit          KIND_DECODE  = 1'b0;
    localparam bit          KIND_ENCODE  = 1'b1;
    localparam int unsigned LAST_SERIAL  = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                           + MAX_YEAR / 400 - 1;
    localparam int          RANDOM_WORDS = 2000;
    localparam int          QUIET_WORDS  = 200;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;

    // Calendar arithmetic, the queue of expected dates and the comparison of result words.
    class date_scoreboard;
        result_t pending_dates[$];
        int      mismatches;
        int      checked;
        int      decodes;
        int      encodes;
        int      flagged;

        // Serial of 1 January of year y.
        static function int unsigned year_base(int unsigned y);
            int unsigned p;
            p = y - 1;
            return 365 * p + p / 4 - p / 100 + p / 400;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        static function int unsigned month_days(int unsigned m, bit lp);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return lp ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        // Works out the result word that one request word must produce.
        function result_t convert(bit kind, logic [47:0] data);
            result_t     res;
            int unsigned ser, r, n400, n100, n4, n1, y, m, d, k;
            bit          lp;
            bit          ok;
            res = '0;
            ok  = 1'b0;
            lp  = 1'b0;
            ser = 0;
            y   = 0;
            m   = 0;
            d   = 0;
            if (kind == KIND_DECODE) begin
                ser = data[21:0];
                if (ser <= LAST_SERIAL) begin
                    // Peel off 400, 100, 4 and 1 year periods; the last century of 400 years and
                    // the last year of 4 are a day longer, so those two digits are clamped at 3.
                    r    = ser;
                    n400 = r / 146097;
                    r    = r - n400 * 146097;
                    n100 = r / 36524;
                    if (n100 > 3)
                        n100 = 3;
                    r  = r - n100 * 36524;
                    n4 = r / 1461;
                    r  = r - n4 * 1461;
                    n1 = r / 365;
                    if (n1 > 3)
                        n1 = 3;
                    r  = r - n1 * 365;
                    y  = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
                    lp = leap_year(y);
                    m  = 1;
                    while (m < 12 && r >= month_days(m, lp)) begin
                        r = r - month_days(m, lp);
                        m++;
                    end
                    d  = r + 1;
                    ok = 1'b1;
                end
            end
            else begin
                d = data[26:22];
                m = data[30:27];
                y = data[44:31];
                if (y >= 1 && y <= MAX_YEAR && m >= 1 && m <= 12 && d >= 1) begin
                    lp = leap_year(y);
                    if (d <= month_days(m, lp)) begin
                        ser = year_base(y);
                        for (k = 1; k < m; k++)
                            ser = ser + month_days(k, lp);
                        ser = ser + d - 1;
                        ok  = 1'b1;
                    end
                end
            end
            if (ok) begin
                res.serial  = ser[21:0];
                res.year    = y[13:0];
                res.month   = m[3:0];
                res.day     = d[4:0];
                res.weekday = 3'(ser % 7);
                res.leap    = lp;
            end
            else begin
                res.error = 1'b1;
            end
            return res;
        endfunction

        function void note_request(bit kind, logic [47:0] data);
            result_t res;
            res = convert(kind, data);
            pending_dates.push_back(res);
            if (kind == KIND_DECODE)
                decodes++;
            else
                encodes++;
            if (res.error)
                flagged++;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("word %0d field %s is %0d, should be %0d",
                                          checked, name, got, want));
        endtask

        // Checks one result word against the oldest expected date.
        task check_result(logic [55:0] word);
            result_t want;
            if (pending_dates.size() == 0) begin
                report_mismatch($sformatf("result word %h arrived with no request open", word));
                return;
            end
            want = pending_dates.pop_front();
            compare_field("serial",  word[21:0],  want.serial);
            compare_field("year",    word[35:22], want.year);
            compare_field("month",   word[39:36], want.month);
            compare_field("day",     word[44:40], want.day);
            compare_field("weekday", word[47:45], want.weekday);
            compare_field("leap",    word[48],    want.leap);
            compare_field("error",   word[49],    want.error);
            compare_field("fill",    word[55:50], 0);
            checked++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    bit quiet;
    bit hold_go;
    bit m_hold;
    int stall_left;

    date_scoreboard sb = new();

    day_serial_date_converter_core #(
        .MAX_YEAR (MAX_YEAR)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [47:0] pack_request(logic [21:0] ser, logic [4:0] d,
                                                 logic [3:0] m, logic [13:0] y);
        return {3'b000, y, m, d, ser};
    endfunction

    // Offers one request word and returns at the edge where it is taken.
    task automatic offer(input bit kind, input logic [47:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, data);
    endtask

    // Sometimes drops valid for a short burst after a word is taken.
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_decode(input int unsigned ser);
        offer(KIND_DECODE, pack_request(22'(ser), 5'd0, 4'd0, 14'd0));
        sender_gap();
    endtask

    task automatic send_encode(input int unsigned d, input int unsigned m, input int unsigned y);
        offer(KIND_ENCODE, pack_request(22'd0, 5'(d), 4'(m), 14'(y)));
        sender_gap();
    endtask

    // Builds one random request: mostly valid dates and in-range serials, the rest
    // out-of-range serials and raw field values. Unused fields carry noise.
    task automatic make_random(output bit kind, output logic [47:0] data);
        int unsigned pick, ser, y, m, d, len;
        pick = $urandom_range(0, 99);
        ser  = 0;
        if (pick < 50) begin
            kind = KIND_DECODE;
            if (pick < 35) begin
                ser = $urandom_range(0, LAST_SERIAL);
            end
            else if (pick < 45) begin
                // Straddle a year boundary.
                y   = $urandom_range(1, MAX_YEAR + 1);
                ser = date_scoreboard::year_base(y) + $urandom_range(0, 2);
                ser = (ser == 0) ? 0 : ser - 1;
            end
            else begin
                ser = $urandom_range(LAST_SERIAL + 1, 22'h3FFFFF);
            end
            data = pack_request(22'(ser), 5'($urandom()), 4'($urandom()), 14'($urandom()));
        end
        else begin
            kind = KIND_ENCODE;
            if (pick < 88) begin
                if ($urandom_range(0, 3) == 0)
                    y = 4 * $urandom_range(1, MAX_YEAR / 4);
                else if ($urandom_range(0, 5) == 0)
                    y = $urandom_range(1, 10);
                else
                    y = $urandom_range(1, MAX_YEAR);
                m   = $urandom_range(1, 12);
                len = date_scoreboard::month_days(m, date_scoreboard::leap_year(y));
                d   = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
            end
            else begin
                d = $urandom_range(0, 31);
                m = $urandom_range(0, 15);
                y = $urandom_range(0, 16383);
            end
            data = pack_request(22'($urandom()), 5'(d), 4'(m), 14'(y));
        end
    endtask

    // Result side: samples each taken word and stalls in random bursts.
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
            m_tready <= rst_n && (stall_left == 0) && !m_hold;
        end
    end

    // One long hold-off on the result side so that the input backs up.
    initial
    begin
        m_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        m_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_hold <= 1'b0;
    end

    // Reset, directed requests, random requests, drain and verdict.
    initial
    begin
        bit          kind;
        logic [47:0] data;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        quiet    = 1'b0;
        hold_go  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decode edges: first days, clamped year digits, leap day, last valid serial
        // and serials past the last year.
        send_decode(0);
        send_decode(1);
        send_decode(59);
        send_decode(1460);
        send_decode(146096);
        send_decode(730119 + 59);
        send_decode(LAST_SERIAL);
        send_decode(LAST_SERIAL + 1);
        send_decode(22'h3FFFFF);

        // Encode edges: range limits, leap days in leap and common years, short months
        // and every field out of range.
        send_encode(1, 1, 1);
        send_encode(31, 12, MAX_YEAR);
        send_encode(29, 2, 2000);
        send_encode(29, 2, 1900);
        send_encode(29, 2, 2024);
        send_encode(29, 2, 2023);
        send_encode(28, 2, 2023);
        send_encode(0, 1, 2000);
        send_encode(31, 4, 2000);
        send_encode(30, 4, 2000);
        send_encode(31, 15, 16383);
        send_encode(15, 0, 500);
        send_encode(1, 13, 500);
        send_encode(1, 1, 0);
        send_encode(1, 1, MAX_YEAR + 1);
        send_encode(31, 12, 16383);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == HOLD_AT)
                hold_go <= 1'b1;
            if (i == RANDOM_WORDS - QUIET_WORDS)
                quiet <= 1'b1;
            make_random(kind, data);
            offer(kind, data);
            sender_gap();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words from %0d decodes and %0d encodes, %0d flagged bad.",
                 sb.checked, sb.decodes, sb.encodes, sb.flagged);
        $display("Output held off %0d cycles once; the last %0d requests ran back to back.",
                 HOLD_CYCLES, QUIET_WORDS);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #1500000;
        $display("Timed out with %0d results outstanding.", sb.pending_dates.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
